@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed")

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen")

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and panel command codes for the rectangle fill generator.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam logic [15:0] CMD_COLUMN   = 16'h002A;
    localparam logic [15:0] CMD_ROW      = 16'h002B;
    localparam logic [15:0] CMD_MEMWRITE = 16'h002C;

    // One clipped axis: first and last pixel position and the span.
    typedef struct packed {
        logic [15:0] first;
        logic [15:0] final_pos;
        logic [15:0] size;
    } axis_t;

    // Everything the output sequencer needs for one command burst.
    typedef struct packed {
        logic [15:0] x_first;
        logic [15:0] x_last;
        logic [15:0] y_first;
        logic [15:0] y_last;
        logic [15:0] colour;
        logic [16:0] count;
    } burst_t;

endpackage

@@ hw/rtl/rfc_axis_clip.sv @@
// ----------------------------------------------------------------------------
// rfc_axis_clip
// Flips a negative span, rejects off-screen spans and clips one axis.
// ----------------------------------------------------------------------------
module rfc_axis_clip #(
    parameter int LIMIT = 240
) (
    input  logic signed [15:0] pos,
    input  logic signed [15:0] size,
    output logic               drop,
    output rfc_pkg::axis_t     res
);

    localparam logic signed [15:0] LIM = 16'(LIMIT);

    logic signed [15:0] p0;
    logic signed [15:0] s0;
    logic signed [15:0] e0;
    logic signed [15:0] p1;
    logic signed [15:0] s1;
    logic signed [15:0] s2;

    always_comb
    begin
        // A negative span is mirrored so that p0 is its low edge and pos its high edge.
        if (size < 16'sd0)
        begin
            p0 = pos + size + 16'sd1;
            s0 = -size;
        end
        else
        begin
            p0 = pos;
            s0 = size;
        end

        e0 = p0 + s0 - 16'sd1;

        if (p0 < 16'sd0)
        begin
            p1 = 16'sd0;
            s1 = e0 + 16'sd1;
        end
        else
        begin
            p1 = p0;
            s1 = s0;
        end

        // Right or bottom clip measures from the already clipped start.
        s2 = (e0 >= LIM) ? (LIM - p1) : s1;

        drop = (size == 16'sd0) || (p0 >= LIM) || (e0 < 16'sd0);

        res.first     = p1;
        res.size      = s2;
        res.final_pos = p1 + s2 - 16'sd1;
    end

endmodule

@@ hw/rtl/rfc_burst.sv @@
// ----------------------------------------------------------------------------
// rfc_burst
// Holds one clipped rectangle and plays out its eight panel transactions.
// ----------------------------------------------------------------------------
module rfc_burst (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_ready,
    input  rfc_pkg::burst_t       load_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_command,
    output logic [15:0]           word,
    output logic [16:0]           repeat_res,
    output logic                  last
);

    typedef enum logic [7:0] {
        S_COL_CMD   = 8'b0000_0001,
        S_COL_START = 8'b0000_0010,
        S_COL_END   = 8'b0000_0100,
        S_ROW_CMD   = 8'b0000_1000,
        S_ROW_START = 8'b0001_0000,
        S_ROW_END   = 8'b0010_0000,
        S_MEM_CMD   = 8'b0100_0000,
        S_FILL      = 8'b1000_0000
    } step_t;

    rfc_pkg::burst_t burst_reg;
    logic            valid_reg;
    logic            valid_next;
    step_t           step_reg;
    step_t           step_next;
    step_t           step_adv;
    logic            take;
    logic            done;

    assign take       = valid_reg && out_ready;
    assign done       = take && (step_reg == S_FILL);
    assign load_ready = !valid_reg || done;
    assign out_valid  = valid_reg;

    always_comb
    begin
        step_adv = S_COL_CMD;
        unique case (step_reg)
            S_COL_CMD:   step_adv = S_COL_START;
            S_COL_START: step_adv = S_COL_END;
            S_COL_END:   step_adv = S_ROW_CMD;
            S_ROW_CMD:   step_adv = S_ROW_START;
            S_ROW_START: step_adv = S_ROW_END;
            S_ROW_END:   step_adv = S_MEM_CMD;
            S_MEM_CMD:   step_adv = S_FILL;
            S_FILL:      step_adv = S_COL_CMD;
            default:     step_adv = S_COL_CMD;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (load_valid && load_ready)
        begin
            valid_next = 1'b1;
            step_next  = S_COL_CMD;
        end
        else if (take)
        begin
            valid_next = !done;
            step_next  = step_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= S_COL_CMD;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            burst_reg <= load_data;
        end
    end

    always_comb
    begin
        is_command = 1'b0;
        word       = burst_reg.colour;
        repeat_res = 17'd1;
        last       = 1'b0;
        unique case (step_reg)
            S_COL_CMD:
            begin
                is_command = 1'b1;
                word       = rfc_pkg::CMD_COLUMN;
            end
            S_COL_START: word = burst_reg.x_first;
            S_COL_END:   word = burst_reg.x_last;
            S_ROW_CMD:
            begin
                is_command = 1'b1;
                word       = rfc_pkg::CMD_ROW;
            end
            S_ROW_START: word = burst_reg.y_first;
            S_ROW_END:   word = burst_reg.y_last;
            S_MEM_CMD:
            begin
                is_command = 1'b1;
                word       = rfc_pkg::CMD_MEMWRITE;
            end
            S_FILL:
            begin
                word       = burst_reg.colour;
                repeat_res = burst_reg.count;
                last       = 1'b1;
            end
            default:
            begin
                is_command = 1'b0;
                word       = burst_reg.colour;
            end
        endcase
    end

endmodule

@@ hw/rtl/display_rect_fill_command_gen.sv @@
// ----------------------------------------------------------------------------
// display_rect_fill_command_gen
// Clips a signed rectangle fill request to the panel and emits the
// column, row and memory-write command stream with one fill transaction.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | left, top, width, height, colour
//  out     | out_valid / out_ready| is_command, word, repeat_res, last
//
// A request passes an input register, a clip register and a burst register;
// its first transaction appears once it reaches the burst register.
// Each drawn rectangle gives eight output transactions, one per cycle while
// out_ready is high, so the output sequencer sets the sustained request rate;
// requests that draw nothing vanish in the clip stage.
// Reset clears all valid flags; a stalled output holds the whole pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module display_rect_fill_command_gen #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left,
    input  logic signed [15:0] top,
    input  logic signed [15:0] width,
    input  logic signed [15:0] height,
    input  logic [15:0]        colour,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_command,
    output logic [15:0]        word,
    output logic [16:0]        repeat_res,
    output logic               last
);

    // Input register.
    logic               in_valid_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] top_reg;
    logic signed [15:0] width_reg;
    logic signed [15:0] height_reg;
    logic [15:0]        colour_reg;

    // Clip register.
    logic               clip_valid_reg;
    logic               clip_ready;
    rfc_pkg::axis_t     clip_x_reg;
    rfc_pkg::axis_t     clip_y_reg;
    logic [15:0]        clip_colour_reg;

    logic               drop_x;
    logic               drop_y;
    rfc_pkg::axis_t     axis_x;
    rfc_pkg::axis_t     axis_y;
    logic               burst_ready;
    rfc_pkg::burst_t    burst_in;
    logic [31:0]        product;

    assign in_ready   = !in_valid_reg || clip_ready;
    assign clip_ready = !clip_valid_reg || burst_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            left_reg   <= left;
            top_reg    <= top;
            width_reg  <= width;
            height_reg <= height;
            colour_reg <= colour;
        end
    end

    rfc_axis_clip #(
        .LIMIT (SCREEN_WIDTH)
    ) u_clip_x (
        .pos  (left_reg),
        .size (width_reg),
        .drop (drop_x),
        .res  (axis_x)
    );

    rfc_axis_clip #(
        .LIMIT (SCREEN_HEIGHT)
    ) u_clip_y (
        .pos  (top_reg),
        .size (height_reg),
        .drop (drop_y),
        .res  (axis_y)
    );

    // A rectangle with no visible pixel is never marked valid in the clip register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_valid_reg <= 1'b0;
        end
        else if (clip_ready)
        begin
            clip_valid_reg <= in_valid_reg && !drop_x && !drop_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clip_ready && in_valid_reg)
        begin
            clip_x_reg      <= axis_x;
            clip_y_reg      <= axis_y;
            clip_colour_reg <= colour_reg;
        end
    end

    assign product = {16'h0000, clip_x_reg.size} * {16'h0000, clip_y_reg.size};

    always_comb
    begin
        burst_in.x_first = clip_x_reg.first;
        burst_in.x_last  = clip_x_reg.final_pos;
        burst_in.y_first = clip_y_reg.first;
        burst_in.y_last  = clip_y_reg.final_pos;
        burst_in.colour  = clip_colour_reg;
        burst_in.count   = product[16:0];
    end

    rfc_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (clip_valid_reg),
        .load_ready (burst_ready),
        .load_data  (burst_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_command (is_command),
        .word       (word),
        .repeat_res (repeat_res),
        .last       (last)
    );

    `ASSERT_NEVER(a_empty_clip, clk, rst_n,
        clip_valid_reg && (clip_x_reg.size == 16'd0 || clip_y_reg.size == 16'd0));
    `ASSERT_PROP(a_cmd_single, clk, rst_n,
        (out_valid && is_command) |-> (repeat_res == 17'd1 && !last));
    `ASSERT_PROP(a_burst_unbroken, clk, rst_n,
        (out_valid && out_ready && !last) |=> out_valid);
    `ASSERT_PROP(a_burst_start, clk, rst_n,
        (out_valid && out_ready && last) |=>
            (!out_valid || (is_command && word == rfc_pkg::CMD_COLUMN)));

endmodule
